// ===== src/mfp_pkg.sv =====
`timescale 1ns / 1ps

package mfp_pkg;

	localparam int BYTE_W    = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 16;
	localparam int COUNT_W   = 17;

	localparam logic [31:0]        HDR_BYTES    = 32'd38;
	localparam logic [COUNT_W-1:0] HDR_LAST_POS = 17'd37;
	localparam logic [COUNT_W-1:0] LEN_LAST_POS = 17'd3;
	localparam logic [31:0]        MAGIC_VALUE  = 32'h5042464d;

	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_VERSION = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_NAME_LENGTH  = 1'b1;

	localparam logic [15:0] EXPECTED_VERSION_RST = 16'd1;
	localparam logic [15:0] MAX_NAME_LENGTH_RST  = 16'd255;

	localparam logic [2:0] ST_OK            = 3'd0;
	localparam logic [2:0] ST_BAD_LENGTH    = 3'd1;
	localparam logic [2:0] ST_BAD_MAGIC     = 3'd2;
	localparam logic [2:0] ST_BAD_VERSION   = 3'd3;
	localparam logic [2:0] ST_EMPTY_NAME    = 3'd4;
	localparam logic [2:0] ST_NAME_TOO_LONG = 3'd5;
	localparam logic [2:0] ST_LEN_MISMATCH  = 3'd6;
	localparam logic [2:0] ST_ZERO_CHUNK    = 3'd7;

	typedef enum logic [2:0] {
		PH_LENGTH,
		PH_HEADER,
		PH_NAME,
		PH_DRAIN,
		PH_HALT
	} phase_t;

	typedef struct packed {
		logic [15:0] expected_version;
		logic [15:0] max_name_length;
	} mfp_cfg_t;

	typedef struct packed {
		logic              valid;
		logic              kind;
		logic [BYTE_W-1:0] data_byte;
	} mfp_item_t;

	typedef struct packed {
		logic              has_name_byte;
		logic [BYTE_W-1:0] name_byte;
		logic              manifest_end;
		logic [2:0]        status;
		logic [15:0]       version;
		logic [15:0]       name_length;
		logic [63:0]       file_bytes;
		logic [31:0]       chunk_bytes;
		logic [63:0]       chunk_total;
		logic [63:0]       session_tag;
	} mfp_result_t;

endpackage

// ===== src/mfp_if.sv =====
`timescale 1ns / 1ps

interface mfp_in_if;
	logic                       valid;
	logic                       ready;
	logic                       kind;
	logic [mfp_pkg::BYTE_W-1:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface mfp_out_if;
	logic                       valid;
	logic                       ready;
	logic                       has_name_byte;
	logic [mfp_pkg::BYTE_W-1:0] name_byte;
	logic                       manifest_end;
	logic [2:0]                 status;
	logic [15:0]                version;
	logic [15:0]                name_length;
	logic [63:0]                file_bytes;
	logic [31:0]                chunk_bytes;
	logic [63:0]                chunk_total;
	logic [63:0]                session_tag;

	modport source (
		output valid, output has_name_byte, output name_byte, output manifest_end,
		output status, output version, output name_length, output file_bytes,
		output chunk_bytes, output chunk_total, output session_tag, input ready
	);
	modport sink (
		input valid, input has_name_byte, input name_byte, input manifest_end,
		input status, input version, input name_length, input file_bytes,
		input chunk_bytes, input chunk_total, input session_tag, output ready
	);
endinterface

// ===== src/mfp_in_reg.sv =====
`timescale 1ns / 1ps

module mfp_in_reg (
	input  logic               clk,
	input  logic               arst_n,
	mfp_in_if.sink             in_ch,
	input  logic               take,
	output mfp_pkg::mfp_item_t item
);
	import mfp_pkg::*;

	mfp_item_t item_s1;

	assign in_ch.ready = !item_s1.valid || take;
	assign item        = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (in_ch.valid && in_ch.ready) begin
			item_s1.valid     <= 1'b1;
			item_s1.kind      <= in_ch.kind;
			item_s1.data_byte <= in_ch.data_byte;
		end else if (take) begin
			item_s1.valid <= 1'b0;
		end
	end

endmodule

// ===== src/mfp_parser.sv =====
`timescale 1ns / 1ps

module mfp_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  mfp_pkg::mfp_cfg_t  cfg,
	input  mfp_pkg::mfp_item_t item,
	output logic               take,
	mfp_out_if.source          out_ch
);
	import mfp_pkg::*;

	phase_t             phase_q, phase_d;
	logic [COUNT_W-1:0] byte_count_q, byte_count_d;
	logic [31:0]        frame_length_q, frame_length_d;
	logic [31:0]        magic_q, magic_d;
	logic [15:0]        version_q, version_d;
	logic [15:0]        name_len_q, name_len_d;
	logic [63:0]        file_bytes_q, file_bytes_d;
	logic [31:0]        chunk_bytes_q, chunk_bytes_d;
	logic [63:0]        chunk_total_q, chunk_total_d;
	logic [63:0]        session_q, session_d;
	logic [2:0]         pending_q, pending_d;

	logic               out_valid_q;
	mfp_result_t        out_q;
	logic               res_valid;
	mfp_result_t        res;

	logic [COUNT_W-1:0] bc_inc;
	logic [31:0]        len_next;
	logic               len_last;
	logic               len_bad;
	logic               hdr_last;
	logic               frame_done;
	logic [2:0]         hdr_status;
	logic [5:0]         pos;
	logic [BYTE_W-1:0]  b;
	logic               run;

	assign take     = item.valid && (!out_valid_q || out_ch.ready);
	assign run      = take && !item.kind;
	assign b        = item.data_byte;
	assign pos      = byte_count_q[5:0];
	assign bc_inc   = byte_count_q + 17'd1;
	assign len_next = {frame_length_q[23:0], b};
	assign len_last = byte_count_q == LEN_LAST_POS;
	assign len_bad  = (len_next < HDR_BYTES) ||
		(len_next > HDR_BYTES + {16'd0, cfg.max_name_length});
	assign hdr_last   = byte_count_q == HDR_LAST_POS;
	assign frame_done = {15'd0, bc_inc} >= frame_length_q;

	always_comb begin
		if (magic_q != MAGIC_VALUE) begin
			hdr_status = ST_BAD_MAGIC;
		end else if (version_q != cfg.expected_version) begin
			hdr_status = ST_BAD_VERSION;
		end else if (name_len_q == 16'd0) begin
			hdr_status = ST_EMPTY_NAME;
		end else if (name_len_q > cfg.max_name_length) begin
			hdr_status = ST_NAME_TOO_LONG;
		end else if (HDR_BYTES + {16'd0, name_len_q} != frame_length_q) begin
			hdr_status = ST_LEN_MISMATCH;
		end else if (chunk_bytes_q == 32'd0) begin
			hdr_status = ST_ZERO_CHUNK;
		end else begin
			hdr_status = ST_OK;
		end
	end

	// next state
	always_comb begin
		phase_d        = phase_q;
		byte_count_d   = byte_count_q;
		frame_length_d = frame_length_q;
		magic_d        = magic_q;
		version_d      = version_q;
		name_len_d     = name_len_q;
		file_bytes_d   = file_bytes_q;
		chunk_bytes_d  = chunk_bytes_q;
		chunk_total_d  = chunk_total_q;
		session_d      = session_q;
		pending_d      = pending_q;
		if (take && item.kind) begin
			phase_d        = PH_LENGTH;
			byte_count_d   = '0;
			frame_length_d = '0;
			magic_d        = '0;
			version_d      = '0;
			name_len_d     = '0;
			file_bytes_d   = '0;
			chunk_bytes_d  = '0;
			chunk_total_d  = '0;
			session_d      = '0;
			pending_d      = ST_OK;
		end else if (run) begin
			case (phase_q)
				PH_LENGTH: begin
					frame_length_d = len_next;
					if (len_last) begin
						byte_count_d = '0;
						phase_d      = len_bad ? PH_HALT : PH_HEADER;
					end else begin
						byte_count_d = bc_inc;
					end
				end
				PH_HEADER: begin
					byte_count_d = bc_inc;
					if (pos inside {[6'd0:6'd3]}) begin
						magic_d = {magic_q[23:0], b};
					end else if (pos inside {[6'd4:6'd5]}) begin
						version_d = {version_q[7:0], b};
					end else if (pos inside {[6'd6:6'd7]}) begin
						name_len_d = {name_len_q[7:0], b};
					end else if (pos inside {[6'd8:6'd15]}) begin
						file_bytes_d = {file_bytes_q[55:0], b};
					end else if (pos inside {[6'd16:6'd19]}) begin
						chunk_bytes_d = {chunk_bytes_q[23:0], b};
					end else if (pos inside {[6'd20:6'd27]}) begin
						chunk_total_d = {chunk_total_q[55:0], b};
					end else if (pos inside {[6'd28:6'd35]}) begin
						session_d = {session_q[55:0], b};
					end
					if (hdr_last) begin
						pending_d = hdr_status;
						if (hdr_status == ST_OK) begin
							phase_d = PH_NAME;
						end else if (frame_done) begin
							phase_d = PH_LENGTH;
						end else begin
							phase_d = PH_DRAIN;
						end
					end
				end
				PH_NAME, PH_DRAIN: begin
					byte_count_d = bc_inc;
					if (frame_done) begin
						phase_d = PH_LENGTH;
					end
				end
				default: begin
				end
			endcase
			if (phase_d == PH_LENGTH && phase_q != PH_LENGTH) begin
				byte_count_d   = '0;
				frame_length_d = '0;
				magic_d        = '0;
				version_d      = '0;
				name_len_d     = '0;
				file_bytes_d   = '0;
				chunk_bytes_d  = '0;
				chunk_total_d  = '0;
				session_d      = '0;
				pending_d      = ST_OK;
			end
		end
	end

	// result
	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		if (run) begin
			case (phase_q)
				PH_LENGTH: begin
					if (len_last && len_bad) begin
						res_valid        = 1'b1;
						res.manifest_end = 1'b1;
						res.status       = ST_BAD_LENGTH;
					end
				end
				PH_HEADER: begin
					if (hdr_last && hdr_status != ST_OK && frame_done) begin
						res_valid = 1'b1;
						res.manifest_end = 1'b1;
						res.status       = hdr_status;
					end
				end
				PH_NAME: begin
					res_valid         = 1'b1;
					res.has_name_byte = 1'b1;
					res.name_byte     = b;
					if (frame_done) begin
						res.manifest_end = 1'b1;
						res.status       = ST_OK;
					end
				end
				PH_DRAIN: begin
					if (frame_done) begin
						res_valid        = 1'b1;
						res.manifest_end = 1'b1;
						res.status       = pending_q;
					end
				end
				default: begin
				end
			endcase
			if (res.manifest_end && phase_q != PH_LENGTH) begin
				res.version     = version_q;
				res.name_length = name_len_q;
				res.file_bytes  = file_bytes_q;
				res.chunk_bytes = chunk_bytes_q;
				res.chunk_total = chunk_total_q;
				res.session_tag = session_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_LENGTH;
			byte_count_q   <= '0;
			frame_length_q <= '0;
			magic_q        <= '0;
			version_q      <= '0;
			name_len_q     <= '0;
			file_bytes_q   <= '0;
			chunk_bytes_q  <= '0;
			chunk_total_q  <= '0;
			session_q      <= '0;
			pending_q      <= ST_OK;
			out_valid_q    <= 1'b0;
		end else begin
			phase_q        <= phase_d;
			byte_count_q   <= byte_count_d;
			frame_length_q <= frame_length_d;
			magic_q        <= magic_d;
			version_q      <= version_d;
			name_len_q     <= name_len_d;
			file_bytes_q   <= file_bytes_d;
			chunk_bytes_q  <= chunk_bytes_d;
			chunk_total_q  <= chunk_total_d;
			session_q      <= session_d;
			pending_q      <= pending_d;
			if (take) begin
				out_valid_q <= res_valid;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.has_name_byte = out_q.has_name_byte;
	assign out_ch.name_byte     = out_q.name_byte;
	assign out_ch.manifest_end  = out_q.manifest_end;
	assign out_ch.status        = out_q.status;
	assign out_ch.version       = out_q.version;
	assign out_ch.name_length   = out_q.name_length;
	assign out_ch.file_bytes    = out_q.file_bytes;
	assign out_ch.chunk_bytes   = out_q.chunk_bytes;
	assign out_ch.chunk_total   = out_q.chunk_total;
	assign out_ch.session_tag   = out_q.session_tag;

endmodule

// ===== src/manifest_frame_parser_top.sv =====
`timescale 1ns / 1ps

// Manifest frame parser: one received byte per input transaction, one byte per clock
// sustained. Each transaction passes an input register and one parse step into the
// result register, which loads a result as its byte leaves the input register;
// input and output are decoupled by those registers and stall only when the result
// register is full and not taken. A frame is a 4-byte big-endian length, a 38-byte
// header and the file name. Name bytes are emitted only for a header that passes all
// checks; the last name byte carries the closing status and header fields. A failed
// header drains the rest of the frame silently and closes on its last byte. A bad
// length prefix closes with status 1 and halts parsing until a restart transaction
// (kind 1), which gives no result. Write configuration registers only while the block
// is idle.
module manifest_frame_parser_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mfp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mfp_pkg::CFG_W-1:0]        cfg_data,
	mfp_in_if.sink                           in_ch,
	mfp_out_if.source                        out_ch
);
	import mfp_pkg::*;

	mfp_cfg_t  cfg_q;
	mfp_item_t item;
	logic      take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_version <= EXPECTED_VERSION_RST;
			cfg_q.max_name_length  <= MAX_NAME_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EXPECTED_VERSION: cfg_q.expected_version <= cfg_data;
				REG_MAX_NAME_LENGTH:  cfg_q.max_name_length  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mfp_in_reg u_in_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.take   (take),
		.item   (item)
	);

	mfp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.item   (item),
		.take   (take),
		.out_ch (out_ch)
	);

	a_restart_silent: assert property (@(posedge clk) disable iff (!arst_n)
		take && item.kind |=> !out_ch.valid)
		else $error("restart transaction produced a result");

	a_open_is_name: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.manifest_end |->
		out_ch.has_name_byte && out_ch.status == ST_OK)
		else $error("non-closing result without a name byte");

	a_name_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.has_name_byte |-> out_ch.name_byte == '0)
		else $error("name byte set without has_name_byte");

	a_bad_len_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status == ST_BAD_LENGTH |->
		out_ch.version == '0 && out_ch.file_bytes == '0 && out_ch.session_tag == '0 &&
		!out_ch.has_name_byte)
		else $error("bad length result carries header fields");

endmodule
